@@ sv/acia_pkg.sv @@
// Shared types, status bit positions and word format tables for the ACIA.
package acia_pkg;

    // Transaction kind carried in the input tuser field
    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // Framer phase, shared by the receive and transmit sides
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_DATA   = 3'd1,
        PH_PARITY = 3'd2,
        PH_STOP1  = 3'd3,
        PH_STOP2  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        PAR_NONE = 2'd0,
        PAR_EVEN = 2'd1,
        PAR_ODD  = 2'd2
    } t_parity;

    // Status register bit positions
    localparam int ST_RDRF = 0;
    localparam int ST_TDRE = 1;
    localparam int ST_FE   = 4;
    localparam int ST_OVRN = 5;
    localparam int ST_PE   = 6;
    localparam int ST_IRQ  = 7;

    localparam logic [7:0] STATUS_RESET = 8'h02;

    // Control register codes
    localparam logic [1:0] DIV_MASTER_RESET = 2'b11;
    localparam logic [1:0] TXC_IRQ_ON       = 2'b01;

    // Framer state of one direction
    typedef struct packed {
        t_phase     phase;
        logic [7:0] shift;
        logic [3:0] count;
        logic       parity_acc;
    } t_framer;

    // Data bits per word format: 7E2, 7O2, 7E1, 7O1, 8N2, 8N1, 8E1, 8O1
    function automatic logic [3:0] fmt_data_bits(input logic [2:0] fmt);
        return fmt[2] ? 4'd8 : 4'd7;
    endfunction

    function automatic t_parity fmt_parity(input logic [2:0] fmt);
        t_parity p;
        unique case (fmt)
            3'd0, 3'd2, 3'd6: p = PAR_EVEN;
            3'd1, 3'd3, 3'd7: p = PAR_ODD;
            default:          p = PAR_NONE;
        endcase
        return p;
    endfunction

    function automatic logic fmt_two_stop(input logic [2:0] fmt);
        return (fmt == 3'd0) || (fmt == 3'd1) || (fmt == 3'd4);
    endfunction

endpackage

@@ sv/acia_rx_framer.sv @@
// Receive framer: next receive state and status for one bit tick.
module acia_rx_framer
    import acia_pkg::*;
(
    input  t_framer    i_state,
    input  logic [7:0] i_status,
    input  logic [2:0] i_fmt,
    input  logic       i_irq_en,
    input  logic       i_bit,
    output t_framer    o_state,
    output logic [7:0] o_status,
    output logic       o_hold_load
);

    t_parity    w_par;
    logic       w_want;
    logic [3:0] w_count;

    assign w_par   = fmt_parity(i_fmt);
    assign w_want  = (w_par == PAR_ODD) ? ~i_state.parity_acc : i_state.parity_acc;
    assign w_count = i_state.count + 4'd1;

    // Frame the incoming bit
    always_comb begin
        o_state     = i_state;
        o_status    = i_status;
        o_hold_load = 1'b0;
        unique case (i_state.phase)
            PH_DATA: begin
                o_state.shift[i_state.count[2:0]] = i_state.shift[i_state.count[2:0]] | i_bit;
                o_state.parity_acc = i_state.parity_acc ^ i_bit;
                o_state.count      = w_count;
                if (w_count >= fmt_data_bits(i_fmt)) begin
                    o_state.phase = (w_par != PAR_NONE) ? PH_PARITY : PH_STOP1;
                end
            end
            PH_PARITY: begin
                o_status[ST_PE] = (i_bit != w_want);
                o_state.phase   = PH_STOP1;
            end
            PH_STOP1: begin
                o_status[ST_FE] = ~i_bit;
                if (fmt_two_stop(i_fmt)) begin
                    o_state.phase = PH_STOP2;
                end else begin
                    o_state.phase = PH_IDLE;
                    o_hold_load   = 1'b1;
                end
            end
            PH_STOP2: begin
                o_status[ST_FE] = ~i_bit;
                o_state.phase   = PH_IDLE;
                o_hold_load     = 1'b1;
            end
            default: begin
                // Idle: wait for a start bit
                o_state.phase = PH_IDLE;
                if (!i_bit) begin
                    o_state.phase      = PH_DATA;
                    o_state.shift      = 8'd0;
                    o_state.count      = 4'd0;
                    o_state.parity_acc = 1'b0;
                end
            end
        endcase
        // Completed byte: overrun tracks the previous RDRF
        if (o_hold_load) begin
            o_status[ST_OVRN] = i_status[ST_RDRF];
            o_status[ST_RDRF] = 1'b1;
            o_status[ST_IRQ]  = o_status[ST_IRQ] | i_irq_en;
        end
    end

endmodule

@@ sv/acia_tx_framer.sv @@
// Transmit framer: next transmit state, status and line level for one bit tick.
module acia_tx_framer
    import acia_pkg::*;
(
    input  t_framer    i_state,
    input  logic [7:0] i_status,
    input  logic [2:0] i_fmt,
    input  logic [7:0] i_holding,
    input  logic       i_irq_en,
    output t_framer    o_state,
    output logic [7:0] o_status,
    output logic       o_bit
);

    t_parity    w_par;
    logic [3:0] w_count;
    logic       w_data_bit;

    assign w_par      = fmt_parity(i_fmt);
    assign w_count    = i_state.count + 4'd1;
    assign w_data_bit = i_state.shift[i_state.count[2:0]];

    // Serialize the frame
    always_comb begin
        o_state  = i_state;
        o_status = i_status;
        o_bit    = 1'b1;
        unique case (i_state.phase)
            PH_DATA: begin
                o_bit              = w_data_bit;
                o_state.parity_acc = i_state.parity_acc ^ w_data_bit;
                o_state.count      = w_count;
                if (w_count >= fmt_data_bits(i_fmt)) begin
                    o_state.phase = (w_par != PAR_NONE) ? PH_PARITY : PH_STOP1;
                end
            end
            PH_PARITY: begin
                o_bit         = (w_par == PAR_ODD) ? ~i_state.parity_acc : i_state.parity_acc;
                o_state.phase = PH_STOP1;
            end
            PH_STOP1: begin
                o_state.phase = fmt_two_stop(i_fmt) ? PH_STOP2 : PH_IDLE;
            end
            PH_STOP2: begin
                o_state.phase = PH_IDLE;
            end
            default: begin
                // Idle: start a frame when the transmit register is full
                o_state.phase = PH_IDLE;
                if (!i_status[ST_TDRE]) begin
                    o_state.count      = 4'd0;
                    o_state.parity_acc = 1'b0;
                    o_state.shift      = i_holding;
                    o_status[ST_TDRE]  = 1'b1;
                    o_status[ST_IRQ]   = i_status[ST_IRQ] | i_irq_en;
                    o_state.phase      = PH_DATA;
                    o_bit              = 1'b0;
                end
            end
        endcase
    end

endmodule

@@ sv/acia_serial_bit_framer.sv @@
// 6850-style ACIA with bit-tick serial framing: top level.
//
// Input channel (s_axis): one transaction is a bus read, a bus write or a
// bit tick. tuser selects the kind and register, tdata carries the write
// byte and the receive line level for a tick.
// Output channel (m_axis): exactly one result transaction per input
// transaction, in order: read data (status or receive byte on a read,
// otherwise zero), transmit line level (1 outside ticks) and the IRQ bit.
// An accepted transaction is captured in the input register and is then
// evaluated into the result register, which holds it while the receiver
// stalls. Throughput is one transaction per clock while the receiver does not
// stall; the state update is a short combinational step between the two registers.
// Reset (synchronous, i_rst_n low) empties both registers, idles both
// framers, clears their shift and holding data and sets status to transmit-empty only.
// When the receiver stalls the result register holds, the input register
// still fills, and s_axis tready drops only once both are occupied.
module acia_serial_bit_framer
    import acia_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [7:0] write_data, [8] rx_line, rest zero
    input  logic [2:0]  i_s_axis_tuser,  // [1:0] action, [2] reg_select
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata   // [7:0] read_data, [8] tx_line, [9] irq, rest zero
);

    // Input register
    logic       r_in_valid;
    t_action    r_action;
    logic       r_sel;
    logic [7:0] r_wdata;
    logic       r_rx_line;

    // Result register
    logic       r_out_valid;
    logic [7:0] r_out_rdata;
    logic       r_out_tx;
    logic       r_out_irq;

    // Block state
    t_framer    r_rx, n_rx;
    t_framer    r_tx, n_tx;
    logic [7:0] r_status, n_status;
    logic [7:0] r_rx_hold, n_rx_hold;
    logic [7:0] r_tx_hold, n_tx_hold;
    logic [2:0] r_fmt, n_fmt;
    logic       r_rx_ie, n_rx_ie;
    logic       r_tx_ie, n_tx_ie;
    logic [7:0] n_rdata;
    logic       n_tx_bit;

    logic       w_adv;
    t_framer    w_rx_state;
    logic [7:0] w_rx_status;
    logic       w_rx_load;
    t_framer    w_tx_state;
    logic [7:0] w_tx_status;
    logic       w_tx_bit;

    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_irq, r_out_tx, r_out_rdata};

    acia_rx_framer u_rx (
        .i_state     (r_rx),
        .i_status    (r_status),
        .i_fmt       (r_fmt),
        .i_irq_en    (r_rx_ie),
        .i_bit       (r_rx_line),
        .o_state     (w_rx_state),
        .o_status    (w_rx_status),
        .o_hold_load (w_rx_load)
    );

    // Transmit side sees the status after the receive update of the same tick
    acia_tx_framer u_tx (
        .i_state   (r_tx),
        .i_status  (w_rx_status),
        .i_fmt     (r_fmt),
        .i_holding (r_tx_hold),
        .i_irq_en  (r_tx_ie),
        .o_state   (w_tx_state),
        .o_status  (w_tx_status),
        .o_bit     (w_tx_bit)
    );

    // Evaluate the registered transaction
    always_comb begin
        n_rx      = r_rx;
        n_tx      = r_tx;
        n_status  = r_status;
        n_rx_hold = r_rx_hold;
        n_tx_hold = r_tx_hold;
        n_fmt     = r_fmt;
        n_rx_ie   = r_rx_ie;
        n_tx_ie   = r_tx_ie;
        n_rdata   = 8'd0;
        n_tx_bit  = 1'b1;
        unique case (r_action)
            ACT_READ: begin
                if (r_sel) begin
                    n_rdata           = r_rx_hold;
                    n_status[ST_RDRF] = 1'b0;
                    n_status[ST_OVRN] = 1'b0;
                    n_status[ST_IRQ]  = 1'b0;
                end else begin
                    n_rdata = r_status;
                end
            end
            ACT_WRITE: begin
                if (r_sel) begin
                    n_tx_hold         = r_wdata;
                    n_status[ST_TDRE] = 1'b0;
                    n_status[ST_IRQ]  = 1'b0;
                end else if (r_wdata[1:0] == DIV_MASTER_RESET) begin
                    n_status   = STATUS_RESET;
                    n_rx.phase = PH_IDLE;
                    n_tx.phase = PH_IDLE;
                    n_rx_ie    = 1'b0;
                    n_tx_ie    = 1'b0;
                end else begin
                    n_fmt   = r_wdata[4:2];
                    n_rx_ie = r_wdata[7];
                    n_tx_ie = (r_wdata[6:5] == TXC_IRQ_ON);
                end
            end
            ACT_TICK: begin
                n_rx     = w_rx_state;
                n_tx     = w_tx_state;
                n_status = w_tx_status;
                n_tx_bit = w_tx_bit;
                if (w_rx_load) begin
                    n_rx_hold = r_rx.shift;
                end
            end
            default: begin
            end
        endcase
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_action   <= ACT_NONE;
            r_sel      <= 1'b0;
            r_wdata    <= 8'd0;
            r_rx_line  <= 1'b1;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
            r_action   <= t_action'(i_s_axis_tuser[1:0]);
            r_sel      <= i_s_axis_tuser[2];
            r_wdata    <= i_s_axis_tdata[7:0];
            r_rx_line  <= i_s_axis_tdata[8];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_rdata <= n_rdata;
            r_out_tx    <= n_tx_bit;
            r_out_irq   <= n_status[ST_IRQ];
        end
    end

    // Block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx      <= '{phase: PH_IDLE, shift: 8'd0, count: 4'd0, parity_acc: 1'b0};
            r_tx      <= '{phase: PH_IDLE, shift: 8'd0, count: 4'd0, parity_acc: 1'b0};
            r_status  <= STATUS_RESET;
            r_rx_hold <= 8'd0;
            r_tx_hold <= 8'd0;
            r_fmt     <= 3'd0;
            r_rx_ie   <= 1'b0;
            r_tx_ie   <= 1'b0;
        end else if (w_adv) begin
            r_rx      <= n_rx;
            r_tx      <= n_tx;
            r_status  <= n_status;
            r_rx_hold <= n_rx_hold;
            r_tx_hold <= n_tx_hold;
            r_fmt     <= n_fmt;
            r_rx_ie   <= n_rx_ie;
            r_tx_ie   <= n_tx_ie;
        end
    end

endmodule

@@ tb/tb_acia_serial_bit_framer.sv @@
// Self-checking testbench for the ACIA bit framer: directed and random bus/tick traffic.
module tb_acia_serial_bit_framer;
    timeunit 1ns;
    timeprecision 1ps;
    import acia_pkg::*;

    localparam int RESET_CYCLES     = 11;
    localparam int TARGET_ITEMS     = 1600;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES    = 8;
    localparam int STALL_LIMIT      = 2000;

    // Register select
    localparam logic SEL_CTRL = 1'b0;
    localparam logic SEL_DATA = 1'b1;

    // Control register fields not named in the package
    localparam logic [1:0] DIV_1        = 2'b00;
    localparam logic [1:0] DIV_16       = 2'b01;
    localparam logic [1:0] DIV_64       = 2'b10;
    localparam logic [1:0] TXC_RTS_LOW  = 2'b00;
    localparam logic [1:0] TXC_RTS_HIGH = 2'b10;

    localparam logic [2:0] FMT_7E2 = 3'd0;
    localparam logic [2:0] FMT_7O2 = 3'd1;
    localparam logic [2:0] FMT_8E1 = 3'd6;

    // Word format properties, one bit per format code
    localparam logic [7:0] FMT_EIGHT_BITS = 8'b1111_0000;
    localparam logic [7:0] FMT_TWO_STOP   = 8'b0001_0011;
    localparam logic [7:0] FMT_ODD        = 8'b1000_1010;
    localparam logic [7:0] FMT_NO_PARITY  = 8'b0011_0000;

    typedef struct packed {
        t_action    action;
        logic       reg_sel;
        logic [7:0] wdata;
        logic       rx_line;
    } t_bus_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_line;
        logic       irq;
    } t_reply;

    // Shadow copy of the ACIA plus the queue of replies it predicts
    class acia_shadow;
        t_phase     rx_phase, tx_phase;
        logic [7:0] rx_shift, tx_shift, rx_hold, tx_hold, status, control;
        logic [3:0] rx_count, tx_count;
        logic       rx_par, tx_par, rx_ie, tx_ie, rts;
        logic [2:0] fmt;
        t_reply     expected_replies[$];
        int mismatches = 0, checked = 0;
        int n_reads = 0, n_writes = 0, n_ticks = 0, n_other = 0;
        int n_rx_bytes = 0, n_overruns = 0, n_pe = 0, n_fe = 0, n_tx_bytes = 0;

        function new();
            rx_phase = PH_IDLE;
            tx_phase = PH_IDLE;
            rx_shift = '0;
            tx_shift = '0;
            rx_hold  = '0;
            tx_hold  = '0;
            status   = STATUS_RESET;
            control  = '0;
            rx_count = '0;
            tx_count = '0;
            rx_par   = 1'b0;
            tx_par   = 1'b0;
            rx_ie    = 1'b0;
            tx_ie    = 1'b0;
            rts      = 1'b0;
            fmt      = FMT_7E2;
        endfunction

        function t_parity parity_of(logic [2:0] f);
            if (FMT_NO_PARITY[f])
                return PAR_NONE;
            return FMT_ODD[f] ? PAR_ODD : PAR_EVEN;
        endfunction

        // Completed frame moves into the receive holding register
        function void deliver();
            rx_hold = rx_shift;
            if (status[ST_RDRF])
                n_overruns++;
            status[ST_OVRN] = status[ST_RDRF];
            status[ST_RDRF] = 1'b1;
            if (rx_ie)
                status[ST_IRQ] = 1'b1;
            n_rx_bytes++;
        endfunction

        function void rx_tick(logic lvl);
            logic [3:0] nbits;
            t_parity    par;
            nbits = FMT_EIGHT_BITS[fmt] ? 4'd8 : 4'd7;
            par   = parity_of(fmt);
            case (rx_phase)
                PH_DATA: begin
                    rx_shift[rx_count[2:0]] = rx_shift[rx_count[2:0]] | lvl;
                    rx_par   = rx_par ^ lvl;
                    rx_count = rx_count + 4'd1;
                    if (rx_count >= nbits)
                        rx_phase = (par == PAR_NONE) ? PH_STOP1 : PH_PARITY;
                end
                PH_PARITY: begin
                    status[ST_PE] = (lvl != (rx_par ^ (par == PAR_ODD)));
                    if (status[ST_PE])
                        n_pe++;
                    rx_phase = PH_STOP1;
                end
                PH_STOP1: begin
                    status[ST_FE] = !lvl;
                    if (!lvl)
                        n_fe++;
                    if (FMT_TWO_STOP[fmt]) begin
                        rx_phase = PH_STOP2;
                    end else begin
                        rx_phase = PH_IDLE;
                        deliver();
                    end
                end
                PH_STOP2: begin
                    status[ST_FE] = !lvl;
                    if (!lvl)
                        n_fe++;
                    rx_phase = PH_IDLE;
                    deliver();
                end
                default: begin
                    // hunt for the start bit
                    rx_phase = PH_IDLE;
                    if (!lvl) begin
                        rx_phase = PH_DATA;
                        rx_shift = '0;
                        rx_count = '0;
                        rx_par   = 1'b0;
                    end
                end
            endcase
        endfunction

        function logic tx_tick();
            logic [3:0] nbits;
            t_parity    par;
            logic       lvl;
            nbits = FMT_EIGHT_BITS[fmt] ? 4'd8 : 4'd7;
            par   = parity_of(fmt);
            lvl   = 1'b1;
            case (tx_phase)
                PH_DATA: begin
                    lvl      = tx_shift[tx_count[2:0]];
                    tx_par   = tx_par ^ lvl;
                    tx_count = tx_count + 4'd1;
                    if (tx_count >= nbits)
                        tx_phase = (par == PAR_NONE) ? PH_STOP1 : PH_PARITY;
                end
                PH_PARITY: begin
                    lvl      = tx_par ^ (par == PAR_ODD);
                    tx_phase = PH_STOP1;
                end
                PH_STOP1: tx_phase = FMT_TWO_STOP[fmt] ? PH_STOP2 : PH_IDLE;
                PH_STOP2: tx_phase = PH_IDLE;
                default: begin
                    // pick up a pending transmit byte and send the start bit
                    tx_phase = PH_IDLE;
                    if (!status[ST_TDRE]) begin
                        tx_count       = '0;
                        tx_par         = 1'b0;
                        tx_shift       = tx_hold;
                        status[ST_TDRE] = 1'b1;
                        if (tx_ie)
                            status[ST_IRQ] = 1'b1;
                        tx_phase = PH_DATA;
                        lvl      = 1'b0;
                        n_tx_bytes++;
                    end
                end
            endcase
            return lvl;
        endfunction

        function void write_control(logic [7:0] v);
            control = v;
            if (v[1:0] == DIV_MASTER_RESET) begin
                // master reset keeps the word format
                status   = STATUS_RESET;
                rx_phase = PH_IDLE;
                tx_phase = PH_IDLE;
                rx_ie    = 1'b0;
                tx_ie    = 1'b0;
                rts      = 1'b0;
            end else begin
                fmt   = v[4:2];
                rx_ie = v[7];
                rts   = (v[6:5] == TXC_RTS_HIGH);
                tx_ie = (v[6:5] == TXC_IRQ_ON);
            end
        endfunction

        function t_reply predict(t_bus_item it);
            t_reply r;
            r.read_data = 8'h00;
            r.tx_line   = 1'b1;
            case (it.action)
                ACT_READ: begin
                    n_reads++;
                    if (it.reg_sel == SEL_DATA) begin
                        r.read_data     = rx_hold;
                        status[ST_RDRF] = 1'b0;
                        status[ST_OVRN] = 1'b0;
                        status[ST_IRQ]  = 1'b0;
                    end else begin
                        r.read_data = status;
                    end
                end
                ACT_WRITE: begin
                    n_writes++;
                    if (it.reg_sel == SEL_DATA) begin
                        tx_hold         = it.wdata;
                        status[ST_TDRE] = 1'b0;
                        status[ST_IRQ]  = 1'b0;
                    end else begin
                        write_control(it.wdata);
                    end
                end
                ACT_TICK: begin
                    n_ticks++;
                    rx_tick(it.rx_line);
                    r.tx_line = tx_tick();
                end
                default: n_other++;
            endcase
            r.irq = status[ST_IRQ];
            return r;
        endfunction

        function void note_item(t_bus_item it);
            expected_replies.push_back(predict(it));
        endfunction

        function void check_reply(logic [15:0] data);
            t_reply want;
            if (expected_replies.size() == 0) begin
                $display("%0t: result transaction %h with nothing expected", $time, data);
                mismatches++;
                return;
            end
            want = expected_replies.pop_front();
            checked++;
            if (data[7:0] !== want.read_data) begin
                $display("%0t: read_data expected %02h, got %02h", $time, want.read_data,
                         data[7:0]);
                mismatches++;
            end
            if (data[8] !== want.tx_line) begin
                $display("%0t: tx_line expected %0b, got %0b", $time, want.tx_line, data[8]);
                mismatches++;
            end
            if (data[9] !== want.irq) begin
                $display("%0t: irq expected %0b, got %0b", $time, want.irq, data[9]);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;  // [7:0] write_data, [8] rx_line, rest zero
    logic [2:0]  i_s_axis_tuser = '0;  // [1:0] action, [2] reg_select
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;       // [7:0] read_data, [8] tx_line, [9] irq, rest zero

    acia_shadow board;
    t_bus_item  seen_item;
    logic [2:0] line_fmt = FMT_7E2;   // format the stimulus believes is active
    int         sent_items = 0;
    int         quiet_cycles = 0;
    bit         no_gap_mode = 1'b0;
    bit         long_hold_req = 1'b0;

    acia_serial_bit_framer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Mostly no gap, often short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] ctrl_word(input logic rx_ie, input logic [1:0] txc,
                                             input logic [2:0] f, input logic [1:0] div);
        return {rx_ie, txc, f, div};
    endfunction

    function automatic logic [7:0] random_ctrl();
        return ctrl_word(1'($urandom), 2'($urandom), 3'($urandom), 2'($urandom_range(0, 2)));
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic send_item(input t_bus_item it);
        int gap;
        gap = no_gap_mode ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'd0, it.rx_line, it.wdata};
        i_s_axis_tuser  <= {it.reg_sel, it.action};
        if (it.action == ACT_WRITE && it.reg_sel == SEL_CTRL &&
            it.wdata[1:0] != DIV_MASTER_RESET)
            line_fmt = it.wdata[4:2];
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sent_items++;
    endtask

    task automatic bus_read(input logic sel);
        t_bus_item it;
        it.action  = ACT_READ;
        it.reg_sel = sel;
        it.wdata   = 8'($urandom);
        it.rx_line = 1'($urandom);
        send_item(it);
    endtask

    task automatic bus_write(input logic sel, input logic [7:0] data);
        t_bus_item it;
        it.action  = ACT_WRITE;
        it.reg_sel = sel;
        it.wdata   = data;
        it.rx_line = 1'($urandom);
        send_item(it);
    endtask

    task automatic tick(input logic lvl);
        t_bus_item it;
        it.action  = ACT_TICK;
        it.reg_sel = 1'($urandom);
        it.wdata   = 8'($urandom);
        it.rx_line = lvl;
        send_item(it);
    endtask

    // One serial frame on the receive line in the current format
    task automatic send_frame(input logic [7:0] data, input bit bad_parity, input bit bad_stop);
        logic [2:0] f;
        int         nbits;
        logic       par_lvl;
        f     = line_fmt;
        nbits = FMT_EIGHT_BITS[f] ? 8 : 7;
        tick(1'b0);
        for (int i = 0; i < nbits; i++) begin
            tick(data[i]);
            if ($urandom_range(0, 19) == 0)
                bus_read(SEL_CTRL);
            else if ($urandom_range(0, 59) == 0)
                bus_write(SEL_CTRL, random_ctrl());   // format change mid-frame
        end
        if (!FMT_NO_PARITY[f]) begin
            par_lvl = ^(data & (FMT_EIGHT_BITS[f] ? 8'hFF : 8'h7F)) ^ FMT_ODD[f] ^ bad_parity;
            tick(par_lvl);
        end
        tick(!bad_stop);
        if (FMT_TWO_STOP[f])
            tick(1'b1);
        repeat ($urandom_range(0, 2)) tick(1'b1);
    endtask

    // Stop offering and wait until every result has come back
    task automatic wait_for_drain();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.expected_replies.size() != 0);
    endtask

    // Receiver holds off while the sender streams without gaps
    task automatic backpressure_burst();
        no_gap_mode   = 1'b1;
        long_hold_req = 1'b1;
        send_frame(8'($urandom), 1'b0, 1'b0);
        bus_read(SEL_DATA);
        send_frame(8'($urandom), 1'b0, 1'b0);
        bus_read(SEL_CTRL);
        no_gap_mode = 1'b0;
    endtask

    // Result side: random stalls plus the requested long hold-off
    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else if (!no_gap_mode && $urandom_range(0, 4) == 0) begin
                stall = pick_gap();
                i_m_axis_tready <= 1'b0;
                repeat (stall + 1) @(posedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Monitor both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                seen_item.action  = t_action'(i_s_axis_tuser[1:0]);
                seen_item.reg_sel = i_s_axis_tuser[2];
                seen_item.wdata   = i_s_axis_tdata[7:0];
                seen_item.rx_line = i_s_axis_tdata[8];
                board.note_item(seen_item);
            end
            if (o_m_axis_tvalid && i_m_axis_tready)
                board.check_reply(o_m_axis_tdata);
        end
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
                     quiet_cycles, board.expected_replies.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        int kind;
        board = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset values, unused action, one 8E1 frame with bad parity and stop
        bus_read(SEL_CTRL);
        bus_read(SEL_DATA);
        begin
            t_bus_item nop;
            nop.action  = ACT_NONE;
            nop.reg_sel = SEL_DATA;
            nop.wdata   = 8'hFF;
            nop.rx_line = 1'b0;
            send_item(nop);
        end
        bus_write(SEL_CTRL, ctrl_word(1'b1, TXC_IRQ_ON, FMT_8E1, DIV_16));
        bus_write(SEL_DATA, 8'hFF);
        send_frame(8'h00, 1'b1, 1'b1);
        bus_read(SEL_CTRL);
        bus_read(SEL_DATA);
        bus_write(SEL_CTRL, ctrl_word(1'b0, TXC_RTS_HIGH, FMT_7O2, DIV_64));
        bus_write(SEL_CTRL, 8'hFF);                // master reset
        bus_read(SEL_CTRL);
        bus_write(SEL_CTRL, ctrl_word(1'b0, TXC_RTS_LOW, FMT_7E2, DIV_1));

        wait_for_drain();
        backpressure_burst();

        // Random: mostly well-formed frames, transmit-only runs, noise, master resets, drains and bursts
        while (sent_items < TARGET_ITEMS) begin
            no_gap_mode = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                if ($urandom_range(0, 2) == 0)
                    bus_write(SEL_CTRL, random_ctrl());
                if ($urandom_range(0, 1) == 0)
                    bus_write(SEL_DATA, 8'($urandom));
                send_frame(8'($urandom), $urandom_range(0, 6) == 0, $urandom_range(0, 6) == 0);
                if ($urandom_range(0, 1) == 0)
                    bus_read(SEL_CTRL);
                if ($urandom_range(0, 3) != 0)
                    bus_read(SEL_DATA);
            end else if (kind < 70) begin
                bus_write(SEL_DATA, 8'($urandom));
                repeat ($urandom_range(4, 13)) tick(1'b1);
                bus_read(SEL_CTRL);
            end else if (kind < 88) begin
                repeat ($urandom_range(1, 8)) begin
                    t_bus_item junk;
                    junk.action  = t_action'(2'($urandom));
                    junk.reg_sel = 1'($urandom);
                    junk.wdata   = 8'($urandom);
                    junk.rx_line = 1'($urandom);
                    send_item(junk);
                end
            end else if (kind < 94) begin
                bus_write(SEL_CTRL, ctrl_word(1'($urandom), 2'($urandom), 3'($urandom),
                                              DIV_MASTER_RESET));
                bus_read(SEL_CTRL);
                bus_write(SEL_CTRL, random_ctrl());
            end else if (kind < 97) begin
                wait_for_drain();
            end else begin
                backpressure_burst();
            end
        end
        no_gap_mode = 1'b0;

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d transactions (%0d reads, %0d writes, %0d ticks, %0d unused)",
                 sent_items, board.n_reads, board.n_writes, board.n_ticks, board.n_other);
        $display("Checked %0d; received %0d bytes (%0d overruns, %0d parity, %0d framing), sent %0d",
                 board.checked, board.n_rx_bytes, board.n_overruns, board.n_pe, board.n_fe,
                 board.n_tx_bytes);
        if (board.mismatches == 0 && board.expected_replies.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
